// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions with synchronous reset gating.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== hdl/ept_pkg.sv =====
// ---------------------------------------------------------------------------
// ept_pkg
// Shared constants, triple table and queue status type.
// ---------------------------------------------------------------------------
`default_nettype none

package ept_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int N_SLOT         = 6;
    localparam int SLOT_W         = 3;
    localparam int N_TRI          = 20;
    localparam int TRI_W          = $clog2(N_TRI);
    localparam int Q_DEPTH        = 2;

    // {k, j, i} slot indexes, i < j < k, in nested loop order
    localparam logic [3*SLOT_W-1:0] TRI_IDX [N_TRI] = '{
        {3'd2, 3'd1, 3'd0}, {3'd3, 3'd1, 3'd0}, {3'd4, 3'd1, 3'd0}, {3'd5, 3'd1, 3'd0},
        {3'd3, 3'd2, 3'd0}, {3'd4, 3'd2, 3'd0}, {3'd5, 3'd2, 3'd0}, {3'd4, 3'd3, 3'd0},
        {3'd5, 3'd3, 3'd0}, {3'd5, 3'd4, 3'd0}, {3'd3, 3'd2, 3'd1}, {3'd4, 3'd2, 3'd1},
        {3'd5, 3'd2, 3'd1}, {3'd4, 3'd3, 3'd1}, {3'd5, 3'd3, 3'd1}, {3'd5, 3'd4, 3'd1},
        {3'd4, 3'd3, 3'd2}, {3'd5, 3'd3, 3'd2}, {3'd5, 3'd4, 3'd2}, {3'd5, 3'd4, 3'd3}
    };

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [N_SLOT-1:0] slot_dec(input logic [SLOT_W-1:0] idx);
        slot_dec = N_SLOT'(1) << idx;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ept_queue.sv =====
// ---------------------------------------------------------------------------
// ept_queue
// Short snapshot queue between the capture front and the evaluation back.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ept_queue import ept_pkg::*; #(
    parameter int WIDTH = 18 * COORD_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output t_q_stat               o_stat
);

    localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_CW-1:0]  r_cnt;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        ptr_inc = (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ptr_inc(r_wp);
            if (i_pop)  r_rp <= ptr_inc(r_rp);
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_stat.full)
    `ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_stat.empty)

endmodule

`default_nettype wire

// ===== hdl/ept_front.sv =====
// ---------------------------------------------------------------------------
// ept_front
// Accepts points, tracks the six axis-extreme points, pushes a snapshot
// of them on the last point of a set and restarts.
// ---------------------------------------------------------------------------
`default_nettype none

module ept_front import ept_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [COORD_BITS-1:0]          i_px,
    input  wire logic [COORD_BITS-1:0]          i_py,
    input  wire logic [COORD_BITS-1:0]          i_pz,
    input  wire logic                           i_last,
    input  wire t_q_stat                        i_q_stat,
    output logic                                o_push,
    output logic [N_SLOT*3*COORD_BITS-1:0]      o_snap
);

    localparam int C  = COORD_BITS;
    localparam int PW = 3 * COORD_BITS;

    logic [PW-1:0] r_slot [N_SLOT];
    logic [PW-1:0] n_slot [N_SLOT];
    logic          r_empty;
    logic [PW-1:0] pt;
    logic          acc;

    assign pt      = {i_pz, i_py, i_px};
    assign o_ready = !i_q_stat.full;
    assign acc     = i_valid && o_ready;
    assign o_push  = acc && i_last;

    // min slots 0..2, max slots 3..5; ties go to the newer point
    always_comb begin
        n_slot = r_slot;
        for (int a = 0; a < 3; a++) begin
            if (r_empty || $signed(pt[a*C +: C]) <= $signed(r_slot[a][a*C +: C])) begin
                n_slot[a] = pt;
            end
            if (r_empty || $signed(pt[a*C +: C]) >= $signed(r_slot[a+3][a*C +: C])) begin
                n_slot[a+3] = pt;
            end
        end
    end

    always_comb begin
        for (int s = 0; s < N_SLOT; s++) begin
            o_snap[s*PW +: PW] = n_slot[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= 1'b1;
        end else if (acc) begin
            r_empty <= i_last;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ept_back.sv =====
// ---------------------------------------------------------------------------
// ept_back
// Evaluates the 20 slot triples of one snapshot through a
// cross-product pipeline and keeps the first largest measure.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ept_back import ept_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int AREA_BITS  = 4 * COORD_BITS_DEF + 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [N_SLOT*3*COORD_BITS-1:0] i_q_data,
    input  wire t_q_stat                        i_q_stat,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [9*COORD_BITS-1:0]             o_vtx,
    output logic [AREA_BITS-1:0]                o_area,
    output logic                                o_found
);

    localparam int C  = COORD_BITS;
    localparam int PW = 3 * COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int MW = 2 * DW;
    localparam int XW = MW + 1;
    localparam int SW = 2 * XW;
    localparam int KW = 3 * N_SLOT;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]              r_state;
    logic [TRI_W-1:0]        r_t;
    logic [N_SLOT*PW-1:0]    r_snap;

    // pipeline
    logic                    r_v1, r_v2, r_v3, r_v4;
    logic                    r_l1, r_l2, r_l3, r_l4;
    logic [KW-1:0]           r_k1, r_k2, r_k3, r_k4;
    logic signed [DW-1:0]    r_d [6];
    logic signed [MW-1:0]    r_p [6];
    logic signed [XW-1:0]    r_x [3];
    logic [SW-1:0]           r_sq [3];

    // running best
    logic [AREA_BITS-1:0]    r_best, n_best;
    logic [KW-1:0]           r_bsel, n_bsel;
    logic                    r_found, n_found;

    // output register
    logic                    r_ov;
    logic [9*C-1:0]          r_o_vtx;
    logic [AREA_BITS-1:0]    r_o_area;
    logic                    r_o_found;

    logic [3*SLOT_W-1:0]     idx;
    logic [KW-1:0]           msk;
    logic [PW-1:0]           va, vb, vc;
    logic [AREA_BITS-1:0]    m_sum;
    logic [9*C-1:0]          n_vtx;

    assign o_pop = (r_state == S_IDLE) && !i_q_stat.empty && !r_ov;

    // triple select: one-hot AND-OR over the six snapshot slots
    assign idx = TRI_IDX[r_t];
    assign msk = {slot_dec(idx[3*SLOT_W-1:2*SLOT_W]), slot_dec(idx[2*SLOT_W-1:SLOT_W]),
                  slot_dec(idx[SLOT_W-1:0])};

    always_comb begin
        va = '0;
        vb = '0;
        vc = '0;
        for (int s = 0; s < N_SLOT; s++) begin
            va = va | ({PW{msk[s]}}            & r_snap[s*PW +: PW]);
            vb = vb | ({PW{msk[N_SLOT+s]}}     & r_snap[s*PW +: PW]);
            vc = vc | ({PW{msk[2*N_SLOT+s]}}   & r_snap[s*PW +: PW]);
        end
    end

    // retire: sum of squares, strict compare keeps the earlier triple
    assign m_sum = AREA_BITS'(r_sq[0] + r_sq[1] + r_sq[2]);

    always_comb begin
        n_best  = r_best;
        n_bsel  = r_bsel;
        n_found = r_found;
        if (r_v4 && (m_sum > r_best)) begin
            n_best  = m_sum;
            n_bsel  = r_k4;
            n_found = 1'b1;
        end
    end

    // vertex fields; an empty select (nothing found) yields zeros
    always_comb begin
        n_vtx = '0;
        for (int s = 0; s < N_SLOT; s++) begin
            n_vtx[0 +: PW]    = n_vtx[0 +: PW]    | ({PW{n_bsel[s]}} & r_snap[s*PW +: PW]);
            n_vtx[PW +: PW]   = n_vtx[PW +: PW]   |
                                ({PW{n_bsel[N_SLOT+s]}} & r_snap[s*PW +: PW]);
            n_vtx[2*PW +: PW] = n_vtx[2*PW +: PW] |
                                ({PW{n_bsel[2*N_SLOT+s]}} & r_snap[s*PW +: PW]);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_t     <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_ISSUE);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_ISSUE;
                        r_t     <= '0;
                    end
                end
                S_ISSUE: begin
                    if (r_t == TRI_W'(N_TRI - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_v4 && r_l4) begin
                        r_state <= S_IDLE;
                        r_ov    <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_snap  <= i_q_data;
            r_best  <= '0;
            r_bsel  <= '0;
            r_found <= 1'b0;
        end else begin
            r_best  <= n_best;
            r_bsel  <= n_bsel;
            r_found <= n_found;
        end

        // stage 1: edge vectors u = B - A, w = C - A
        r_l1    <= (r_t == TRI_W'(N_TRI - 1));
        r_k1    <= msk;
        r_d[0]  <= $signed(vb[0 +: C])   - $signed(va[0 +: C]);
        r_d[1]  <= $signed(vb[C +: C])   - $signed(va[C +: C]);
        r_d[2]  <= $signed(vb[2*C +: C]) - $signed(va[2*C +: C]);
        r_d[3]  <= $signed(vc[0 +: C])   - $signed(va[0 +: C]);
        r_d[4]  <= $signed(vc[C +: C])   - $signed(va[C +: C]);
        r_d[5]  <= $signed(vc[2*C +: C]) - $signed(va[2*C +: C]);

        // stage 2: partial products of u x w
        r_l2    <= r_l1;
        r_k2    <= r_k1;
        r_p[0]  <= r_d[1] * r_d[5];
        r_p[1]  <= r_d[2] * r_d[4];
        r_p[2]  <= r_d[2] * r_d[3];
        r_p[3]  <= r_d[0] * r_d[5];
        r_p[4]  <= r_d[0] * r_d[4];
        r_p[5]  <= r_d[1] * r_d[3];

        // stage 3: cross components
        r_l3    <= r_l2;
        r_k3    <= r_k2;
        r_x[0]  <= r_p[0] - r_p[1];
        r_x[1]  <= r_p[2] - r_p[3];
        r_x[2]  <= r_p[4] - r_p[5];

        // stage 4: squares
        r_l4    <= r_l3;
        r_k4    <= r_k3;
        r_sq[0] <= r_x[0] * r_x[0];
        r_sq[1] <= r_x[1] * r_x[1];
        r_sq[2] <= r_x[2] * r_x[2];

        if (r_v4 && r_l4) begin
            r_o_vtx   <= n_vtx;
            r_o_area  <= n_best;
            r_o_found <= n_found;
        end
    end

    assign o_valid = r_ov;
    assign o_vtx   = r_o_vtx;
    assign o_area  = r_o_area;
    assign o_found = r_o_found;

    `ASSERT_IMPL(a_idle_drained, i_clk, i_rst_n, r_state == S_IDLE, !(r_v1 || r_v2 || r_v3 || r_v4))
    `ASSERT_IMPL(a_nf_zero, i_clk, i_rst_n, r_ov && !r_o_found, r_o_area == '0 && r_o_vtx == '0)
    `ASSERT_NEXT(a_pop_start, i_clk, i_rst_n, o_pop, r_state == S_ISSUE && r_t == '0)

endmodule

`default_nettype wire

// ===== hdl/extreme_point_largest_triangle.sv =====
// ---------------------------------------------------------------------------
// extreme_point_largest_triangle
// Largest triangle over the six axis-extreme points of each point set.
// ---------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  s_axis    in   tdata {pz, py, px} (x lowest), tlast = last point of set
//  m_axis    out  tdata {area_measure, v2z..v0x} (v0x lowest), tuser = found
//
//  Ordinary point: one beat per cycle, updates six compare/capture slots.
//  Last point: captured in its cycle, snapshot goes to a 2-deep queue.
//  Evaluation: after a queue pop, 20 triple issues feed a 4-stage
//  cross-product pipeline, one set at a time; the result register
//  must be empty before the next set starts evaluating.
//  s_axis stalls only while the snapshot queue is full. Synchronous reset,
//  no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module extreme_point_largest_triangle import ept_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int AREA_BITS = 4 * COORD_BITS + 4,
    localparam int IN_W      = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((9 * COORD_BITS + AREA_BITS + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // slave side
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire logic [IN_W-1:0]  i_s_axis_tdata,   // px, py, pz
    input  wire logic             i_s_axis_tlast,
    // master side
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output logic [OUT_W-1:0]      o_m_axis_tdata,   // v0x,v0y,v0z,v1x..v2z, area_measure
    output logic [0:0]            o_m_axis_tuser    // found
);

    localparam int C    = COORD_BITS;
    localparam int SNAP = N_SLOT * 3 * COORD_BITS;

    t_q_stat             q_stat;
    logic                q_push, q_pop;
    logic [SNAP-1:0]     snap_in, snap_out;
    logic [9*C-1:0]      res_vtx;
    logic [AREA_BITS-1:0] res_area;
    logic                res_found;

    // capture front
    ept_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_px     (i_s_axis_tdata[0 +: C]),
        .i_py     (i_s_axis_tdata[C +: C]),
        .i_pz     (i_s_axis_tdata[2*C +: C]),
        .i_last   (i_s_axis_tlast),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_snap   (snap_in)
    );

    // snapshot queue
    ept_queue #(
        .WIDTH (SNAP)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (snap_in),
        .i_pop   (q_pop),
        .o_data  (snap_out),
        .o_stat  (q_stat)
    );

    // triple evaluation and result register
    ept_back #(
        .COORD_BITS (COORD_BITS),
        .AREA_BITS  (AREA_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_data (snap_out),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_vtx    (res_vtx),
        .o_area   (res_area),
        .o_found  (res_found)
    );

    // pad up to whole bytes
    assign o_m_axis_tdata    = OUT_W'({res_area, res_vtx});
    assign o_m_axis_tuser[0] = res_found;

endmodule

`default_nettype wire
